// File: rtl/fader_position_send_on_change_macros.svh
// Assertion macros for the fader position sender.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef FADER_POSITION_SEND_ON_CHANGE_MACROS_SVH
`define FADER_POSITION_SEND_ON_CHANGE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define FPSOC_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define FPSOC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPSOC_ASSERT_NOW(name, clk, rstn, ante, cons, msg)
`define FPSOC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/fpsoc_pkg.sv
// Shared types and constants of the fader position sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package fpsoc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 14;

  localparam int ADC_MAX      = 4095;
  localparam int DEADZONE     = 50;
  localparam int POSITION_MAX = 10000;

  localparam logic [POS_W-1:0] MIN_CHANGE_RESET = POS_W'(10);
  localparam logic [POS_W-1:0] POS_MAX_C        = POS_W'(POSITION_MAX);

  // Threshold compares run wide enough for any ADC_MAX in range.
  localparam int CMP_W = 17;
  localparam int HI_THR_I = ADC_MAX - DEADZONE;
  localparam logic [CMP_W-1:0] LO_THR = CMP_W'(DEADZONE);
  localparam logic [CMP_W-1:0] HI_THR = (HI_THR_I < 0) ? '0 : CMP_W'(HI_THR_I);

  // Inner span; the division path is never selected when the deadzones overlap.
  localparam int SPAN = (ADC_MAX > 2 * DEADZONE) ? (ADC_MAX - 2 * DEADZONE) : 1;

  // Reciprocal scaled by POSITION_MAX, rounded up; exact for offsets below 2**SAMPLE_W.
  localparam int      RECIP_SHIFT = $clog2(SPAN) + SAMPLE_W + 1;
  localparam longint  RECIP_L     =
      (((longint'(1) << RECIP_SHIFT) * longint'(POSITION_MAX)) + longint'(SPAN) - 1)
      / longint'(SPAN);
  localparam int      RECIP_W     = $clog2(RECIP_L + 1);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_L);
  localparam int      PROD_W      = RECIP_SHIFT + POS_W + 1;

  typedef struct packed {
    logic             synced;
    logic [POS_W-1:0] last_sent;
  } fpsoc_state_t;

  typedef struct packed {
    logic             emit;
    logic             initial_sync;
    logic [POS_W-1:0] position;
  } fpsoc_decision_t;

endpackage

`default_nettype wire

// File: rtl/fpsoc_map.sv
// Sample to position map: deadzone snap, scaled reciprocal multiply, direction flip.
// Depends on fpsoc_pkg.
`default_nettype none

module fpsoc_map
  import fpsoc_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                at_top_i,
  output logic      [POS_W-1:0]    position_o
);

  logic [CMP_W-1:0]    sample_ext;
  logic                in_lo;
  logic                in_hi;
  logic [SAMPLE_W-1:0] offset;
  logic [PROD_W-1:0]   product;
  logic [POS_W-1:0]    quotient;
  logic [POS_W-1:0]    mapped;

  assign sample_ext = CMP_W'(sample_i);
  assign in_lo      = (sample_ext <= LO_THR);
  assign in_hi      = (sample_ext >= HI_THR);
  assign offset     = sample_i - SAMPLE_W'(DEADZONE);
  assign product    = PROD_W'(offset) * PROD_W'(RECIP_C);
  assign quotient   = product[RECIP_SHIFT +: POS_W];

  always_comb begin
    if (in_lo) begin
      mapped = '0;
    end else if (in_hi) begin
      mapped = POS_MAX_C;
    end else begin
      mapped = quotient;
    end
  end

  // Rest at the bottom: flip the scale.
  assign position_o = at_top_i ? mapped : (POS_MAX_C - mapped);

endmodule

`default_nettype wire

// File: rtl/fpsoc_decide.sv
// Send-on-change decision against the last sent position.
// Depends on fpsoc_pkg.
`default_nettype none

module fpsoc_decide
  import fpsoc_pkg::*;
(
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic                connected_i,
  input  wire fpsoc_state_t        state_i,
  input  wire logic [POS_W-1:0]    min_change_i,
  output fpsoc_decision_t          decision_o
);

  logic [POS_W-1:0] delta;
  logic             pos_end;
  logic             last_end;
  logic             moved;

  assign delta    = (position_i >= state_i.last_sent) ? (position_i - state_i.last_sent)
                                                      : (state_i.last_sent - position_i);
  assign pos_end  = (position_i == '0) || (position_i == POS_MAX_C);
  assign last_end = (state_i.last_sent == '0) || (state_i.last_sent == POS_MAX_C);
  assign moved    = (delta >= min_change_i) || (pos_end && !last_end);

  assign decision_o.emit         = connected_i && (!state_i.synced || moved);
  assign decision_o.initial_sync = !state_i.synced;
  assign decision_o.position     = position_i;

endmodule

`default_nettype wire

// File: rtl/fader_position_send_on_change.sv
// Fader position sender: maps fader samples to positions and forwards on change.
// Each accepted request waits in the input register until the result register can advance;
// if it sends, its position is then loaded into the result register and offered downstream.
// Throughput: one request per cycle, set by the single multiply between input and
// result registers; a stalled result lets one more request in, then holds the input.
// Reset (rst_ni low, asynchronous): clears valids, sync flag, last sent position and
// sets min_change to 10. Depends on fpsoc_pkg, fpsoc_map, fpsoc_decide and the macros.
`default_nettype none
`include "fader_position_send_on_change_macros.svh"

module fader_position_send_on_change
  import fpsoc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: min_change write
  input  wire logic        cfg_we_i,
  input  wire logic [13:0] cfg_wdata_i,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [11:0] adc_sample, [12] connected,
                                           // [13] fader_at_top, [15:14] zero
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [13:0] position, [15:14] zero
  output logic [0:0]       m_axis_tuser    // [0] initial_sync
);

  // Configuration register
  logic [POS_W-1:0] min_change_q;

  // Input register
  logic                in_valid_q;
  logic [SAMPLE_W-1:0] in_sample_q;
  logic                in_connected_q;
  logic                in_at_top_q;

  // Filter state
  fpsoc_state_t        state_q;

  // Result register
  logic                out_valid_q;
  logic [POS_W-1:0]    out_position_q;
  logic                out_initial_q;

  logic                s_accept;
  logic                advance;
  logic                proc;
  logic [POS_W-1:0]    position;
  fpsoc_decision_t     decision;

  // Advance whenever the result register is empty or being drained; while a result
  // waits downstream the input register takes one more request and then holds it.
  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_change_q <= MIN_CHANGE_RESET;
    end else if (cfg_we_i) begin
      min_change_q <= cfg_wdata_i;
    end
  end

  // Input register: hold the request until the decision stage takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_sample_q    <= s_axis_tdata[11:0];
      in_connected_q <= s_axis_tdata[12];
      in_at_top_q    <= s_axis_tdata[13];
    end
  end

  fpsoc_map u_map (
    .sample_i   (in_sample_q),
    .at_top_i   (in_at_top_q),
    .position_o (position)
  );

  fpsoc_decide u_decide (
    .position_i   (position),
    .connected_i  (in_connected_q),
    .state_i      (state_q),
    .min_change_i (min_change_q),
    .decision_o   (decision)
  );

  // Filter state: drop sync while the link is down, record every sent position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (proc) begin
      if (!in_connected_q) begin
        state_q.synced <= 1'b0;
      end else if (decision.emit) begin
        state_q.synced    <= 1'b1;
        state_q.last_sent <= decision.position;
      end
    end
  end

  // Result register: load a result only for requests that send one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= proc && decision.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && decision.emit) begin
      out_position_q <= decision.position;
      out_initial_q  <= decision.initial_sync;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_position_q};
  assign m_axis_tuser  = out_initial_q;

  // A request with the link down must leave the block unsynchronised.
  `FPSOC_ASSERT_NEXT(a_link_down_clears_sync, clk_i, rst_ni,
                     proc && !in_connected_q, !state_q.synced,
                     "sync flag survived a link-down request")
  // A follow-up send is only possible once synchronised.
  `FPSOC_ASSERT_NOW(a_followup_needs_sync, clk_i, rst_ni,
                    proc && decision.emit && !decision.initial_sync, state_q.synced,
                    "follow-up send without prior sync")
  // Every send is recorded as the last sent position and offered downstream.
  `FPSOC_ASSERT_NEXT(a_send_recorded, clk_i, rst_ni,
                     proc && decision.emit,
                     m_axis_tvalid && (state_q.last_sent == out_position_q),
                     "sent position not recorded")

endmodule

`default_nettype wire

// File: tb/tb_fader_position_send_on_change.sv
// Self-checking testbench for fader_position_send_on_change: drives fader samples and
// min_change writes, predicts each position send and compares it with the result stream.
// Depends on fpsoc_pkg and the block's RTL only.
`default_nettype none

module tb_fader_position_send_on_change;
  import fpsoc_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 4;    // lets silent requests still in the pipeline clear after the last send
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 79;
  localparam int DATA_W         = 16;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             initial_sync;
  } position_send_t;

  // Predicts position sends from accepted requests and checks the result stream.
  class fader_send_scoreboard;
    logic [POS_W-1:0] min_change = MIN_CHANGE_RESET;
    logic             synced     = 1'b0;
    logic [POS_W-1:0] last_sent  = '0;
    position_send_t   sends_due[$];
    int               errors     = 0;

    function logic [POS_W-1:0] fader_position(logic [SAMPLE_W-1:0] sample, logic at_top);
      longint s;
      longint mapped;
      s = longint'(sample);
      if (s <= DEADZONE) begin
        mapped = 0;
      end else if (s >= ADC_MAX - DEADZONE) begin
        mapped = POSITION_MAX;
      end else begin
        mapped = ((s - DEADZONE) * POSITION_MAX) / (ADC_MAX - 2 * DEADZONE);
      end
      // bottom rest position inverts the travel
      if (!at_top) mapped = POSITION_MAX - mapped;
      return POS_W'(mapped);
    endfunction

    function bit at_endpoint(logic [POS_W-1:0] p);
      return (p == '0) || (p == POS_W'(POSITION_MAX));
    endfunction

    function void note_request(logic [SAMPLE_W-1:0] sample, logic link, logic at_top);
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] delta;
      position_send_t   send;
      if (!link) begin
        synced = 1'b0;
        return;
      end
      pos   = fader_position(sample, at_top);
      delta = (pos >= last_sent) ? pos - last_sent : last_sent - pos;
      if (!synced || delta >= min_change || (at_endpoint(pos) && !at_endpoint(last_sent))) begin
        send.position     = pos;
        send.initial_sync = !synced;
        sends_due.push_back(send);
        synced    = 1'b1;
        last_sent = pos;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(logic [DATA_W-1:0] tdata, logic isync);
      position_send_t due;
      if (sends_due.size() == 0) begin
        flag($sformatf("unexpected send: position %0d, initial_sync %0b", tdata, isync));
        return;
      end
      due = sends_due.pop_front();
      if (tdata !== {{(DATA_W-POS_W){1'b0}}, due.position})
        flag($sformatf("position: expected %0d, got %0d", due.position, tdata));
      if (isync !== due.initial_sync)
        flag($sformatf("initial_sync: expected %0b, got %0b", due.initial_sync, isync));
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [POS_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // [11:0] adc_sample, [12] connected,
                                          // [13] fader_at_top, [15:14] zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [13:0] position, [15:14] zero
  logic [0:0]        m_axis_tuser;        // [0] initial_sync

  fader_send_scoreboard sb;
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int idle_cycles = 0;

  fader_position_send_on_change u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Offer one request, with an optional random gap first; hold tvalid high afterwards
  // so back-to-back requests need no reassertion.
  task automatic send_sample(input int sample, input logic link, input logic at_top);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DATA_W-SAMPLE_W-2){1'b0}}, at_top, link, SAMPLE_W'(sample)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop tvalid, wait for every predicted send, then let any silent request clear
  // the pipeline so the block is idle.
  task automatic drain_sends();
    s_axis_tvalid <= 1'b0;
    while (sb.sends_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: alternate ready stretches with random stall bursts while stalls are enabled.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 1) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Monitor both streams at the edge and keep the watchdog on accepted traffic.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[SAMPLE_W],
                      s_axis_tdata[SAMPLE_W+1]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int               fader_level;
    int               link_down_left;
    int               pick;
    logic             rest_top;
    logic             link;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0] threshold;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, min_change at its reset value.
    send_sample(100, 1'b0, 1'b1);                     // link down: nothing sent
    send_sample(ADC_MAX, 1'b0, 1'b0);
    send_sample(0, 1'b1, 1'b1);                       // first connected sample
    send_sample(DEADZONE, 1'b1, 1'b1);                // top deadzone edge, no change
    send_sample(DEADZONE + 1, 1'b1, 1'b1);            // small step, held back
    send_sample(ADC_MAX - DEADZONE, 1'b1, 1'b1);      // bottom deadzone edge
    send_sample(ADC_MAX - DEADZONE - 1, 1'b1, 1'b1);  // just inside, held back
    send_sample(2048, 1'b1, 1'b1);
    send_sample(ADC_MAX - DEADZONE - 1, 1'b1, 1'b1);
    send_sample(ADC_MAX - DEADZONE, 1'b1, 1'b1);      // endpoint newly reached
    send_sample(ADC_MAX, 1'b1, 1'b1);                 // endpoint to endpoint, held back
    send_sample(ADC_MAX, 1'b1, 1'b0);                 // rest at bottom inverts
    send_sample(0, 1'b1, 1'b0);
    send_sample(DEADZONE + 1, 1'b1, 1'b0);
    send_sample(2047, 1'b1, 1'b0);
    send_sample(DEADZONE + 1, 1'b1, 1'b0);
    send_sample(DEADZONE, 1'b1, 1'b0);                // endpoint newly reached
    send_sample(100, 1'b0, 1'b0);                     // drop the link, keep last_sent
    send_sample(3000, 1'b1, 1'b1);                    // resync
    send_sample(3001, 1'b1, 1'b1);
    send_sample(0, 1'b0, 1'b1);
    send_sample(ADC_MAX, 1'b1, 1'b0);                 // resync at position 0
    send_sample('h555, 1'b1, 1'b1);
    send_sample('hAAA, 1'b1, 1'b1);

    // Random phases: fader sweeps with random content, link drops and rest flips.
    fader_level    = 2048;
    rest_top       = 1'b1;
    link_down_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_sends();
      case (phase)
        0:       threshold = '0;
        1:       threshold = POS_W'(POSITION_MAX);
        2:       threshold = POS_W'(1);
        3:       threshold = POS_W'($urandom_range(2, 200));
        5:       threshold = POS_W'($urandom_range(10, 60));
        PHASES - 1: threshold = MIN_CHANGE_RESET;
        default: threshold = POS_W'($urandom_range(0, POSITION_MAX));
      endcase
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= threshold;
      @(posedge clk_i);
      cfg_we_i     <= 1'b0;
      sb.min_change = threshold;

      // no idling in every third phase and in the last one
      gaps_on   = (phase < PHASES - 1) && (phase % 3 != 2);
      stalls_on = gaps_on;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: fader_level = $urandom_range(0, ADC_MAX);
          1: fader_level = $urandom_range(0, 1) ? 0 : ADC_MAX;
          2: fader_level = ($urandom_range(0, 1) ? DEADZONE : ADC_MAX - DEADZONE)
                           + $urandom_range(0, 4) - 2;
          default: fader_level = fader_level + $urandom_range(0, 80) - 40;
        endcase
        if (fader_level < 0) fader_level = 0;
        if (fader_level > ADC_MAX) fader_level = ADC_MAX;
        sample = SAMPLE_W'(fader_level);

        if ($urandom_range(0, 39) == 0) rest_top = ~rest_top;
        if (link_down_left == 0 && $urandom_range(0, 29) == 0)
          link_down_left = $urandom_range(1, 4);
        link = (link_down_left == 0);
        if (link_down_left != 0) begin
          link_down_left--;
          // noise on a dead link
          sample = SAMPLE_W'($urandom_range(0, ADC_MAX));
        end
        send_sample(int'(sample), link, rest_top);
      end
    end

    drain_sends();
    if (sb.errors == 0 && sb.sends_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
